// ===== rtl/sckd_pkg.sv =====
// ----------------------------------------------------------------------------
// sckd_pkg
// Shared types, scancode constants and layout tables for the set-1 decoder.
// ----------------------------------------------------------------------------
package sckd_pkg;

	// Key flags kept in the flag RAM
	typedef struct packed {
		logic prefix;
		logic shift;
		logic caps;
	} flags_t;

	localparam int FLAG_W     = $bits(flags_t);
	localparam int FLAG_DEPTH = 1;

	localparam int SCAN_W  = 8;
	localparam int CHAR_W  = 7;
	localparam int KIND_W  = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register word index on the config port
	localparam logic REG_LAYOUT_SELECT = 1'b0;

	// Layout codes
	localparam logic LAYOUT_US = 1'b0;
	localparam logic LAYOUT_FR = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		EV_NONE      = 3'd0,
		EV_CHAR      = 3'd1,
		EV_SUBMIT    = 3'd2,
		EV_BACKSPACE = 3'd3,
		EV_LEFT      = 3'd4,
		EV_RIGHT     = 3'd5,
		EV_HPREV     = 3'd6,
		EV_HNEXT     = 3'd7
	} event_kind_t;

	// Scancodes
	localparam logic [SCAN_W-1:0] SC_PREFIX     = 8'hE0;
	localparam logic [SCAN_W-1:0] SC_LEFT       = 8'h4B;
	localparam logic [SCAN_W-1:0] SC_RIGHT      = 8'h4D;
	localparam logic [SCAN_W-1:0] SC_UP         = 8'h48;
	localparam logic [SCAN_W-1:0] SC_DOWN       = 8'h50;
	localparam logic [SCAN_W-1:0] SC_CAPS       = 8'h3A;
	localparam logic [SCAN_W-1:0] SC_LSHIFT     = 8'h2A;
	localparam logic [SCAN_W-1:0] SC_RSHIFT     = 8'h36;
	localparam logic [SCAN_W-1:0] SC_LSHIFT_REL = 8'hAA;
	localparam logic [SCAN_W-1:0] SC_RSHIFT_REL = 8'hB6;
	localparam logic [SCAN_W-1:0] SC_ENTER      = 8'h1C;
	localparam logic [SCAN_W-1:0] SC_BACKSPACE  = 8'h0E;

	typedef struct packed {
		logic [CHAR_W-1:0] lo;
		logic [CHAR_W-1:0] hi;
	} glyph_pair_t;

	function automatic glyph_pair_t glyph(input logic [CHAR_W-1:0] lo,
					      input logic [CHAR_W-1:0] hi);
		glyph_pair_t g;
		g.lo = lo;
		g.hi = hi;
		return g;
	endfunction

	// US table, make codes 0x00..0x7F
	function automatic glyph_pair_t us_glyph(input logic [CHAR_W-1:0] code);
		glyph_pair_t g;
		case (code)
			7'h02: g = glyph(7'h31, 7'h21);
			7'h03: g = glyph(7'h32, 7'h40);
			7'h04: g = glyph(7'h33, 7'h23);
			7'h05: g = glyph(7'h34, 7'h24);
			7'h06: g = glyph(7'h35, 7'h25);
			7'h07: g = glyph(7'h36, 7'h5E);
			7'h08: g = glyph(7'h37, 7'h26);
			7'h09: g = glyph(7'h38, 7'h2A);
			7'h0A: g = glyph(7'h39, 7'h28);
			7'h0B: g = glyph(7'h30, 7'h29);
			7'h10: g = glyph(7'h71, 7'h51);
			7'h11: g = glyph(7'h77, 7'h57);
			7'h12: g = glyph(7'h65, 7'h45);
			7'h13: g = glyph(7'h72, 7'h52);
			7'h14: g = glyph(7'h74, 7'h54);
			7'h15: g = glyph(7'h79, 7'h59);
			7'h16: g = glyph(7'h75, 7'h55);
			7'h17: g = glyph(7'h69, 7'h49);
			7'h18: g = glyph(7'h6F, 7'h4F);
			7'h19: g = glyph(7'h70, 7'h50);
			7'h1C: g = glyph(7'h0A, 7'h0A);
			7'h1E: g = glyph(7'h61, 7'h41);
			7'h1F: g = glyph(7'h73, 7'h53);
			7'h20: g = glyph(7'h64, 7'h44);
			7'h21: g = glyph(7'h66, 7'h46);
			7'h22: g = glyph(7'h67, 7'h47);
			7'h23: g = glyph(7'h68, 7'h48);
			7'h24: g = glyph(7'h6A, 7'h4A);
			7'h25: g = glyph(7'h6B, 7'h4B);
			7'h26: g = glyph(7'h6C, 7'h4C);
			7'h2C: g = glyph(7'h7A, 7'h5A);
			7'h2D: g = glyph(7'h78, 7'h58);
			7'h2E: g = glyph(7'h63, 7'h43);
			7'h2F: g = glyph(7'h76, 7'h56);
			7'h30: g = glyph(7'h62, 7'h42);
			7'h31: g = glyph(7'h6E, 7'h4E);
			7'h32: g = glyph(7'h6D, 7'h4D);
			7'h39: g = glyph(7'h20, 7'h20);
			default: g = glyph(7'h00, 7'h00);
		endcase
		return g;
	endfunction

	// French table: accented letters folded to plain ASCII
	function automatic glyph_pair_t fr_glyph(input logic [CHAR_W-1:0] code);
		glyph_pair_t g;
		case (code)
			7'h02: g = glyph(7'h26, 7'h31);
			7'h03: g = glyph(7'h65, 7'h32);
			7'h04: g = glyph(7'h22, 7'h33);
			7'h05: g = glyph(7'h27, 7'h34);
			7'h06: g = glyph(7'h28, 7'h35);
			7'h07: g = glyph(7'h2D, 7'h36);
			7'h08: g = glyph(7'h65, 7'h37);
			7'h09: g = glyph(7'h5F, 7'h38);
			7'h0A: g = glyph(7'h63, 7'h39);
			7'h0B: g = glyph(7'h61, 7'h30);
			7'h10: g = glyph(7'h61, 7'h41);
			7'h11: g = glyph(7'h7A, 7'h5A);
			7'h1E: g = glyph(7'h71, 7'h51);
			7'h2C: g = glyph(7'h77, 7'h57);
			7'h32: g = glyph(7'h2C, 7'h3F);
			default: g = us_glyph(code);
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/scancode_to_key_event_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// scancode_to_key_event_decoder_unit
// Path: the word in stage 1 is decoded into the output register.
// Throughput: one word per cycle unless the output stalls; the flag RAM is
// read every cycle and stage 1 writes its updated flags back as it retires.
// Reset: arst_n clears control, layout_select and the flag RAM valid bit,
// so the flags read as all clear at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scancode_to_key_event_decoder_unit
	import sckd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	// scancode input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [SCAN_W-1:0]  scan_byte,

	// key event output
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  event_kind,
	output logic [CHAR_W-1:0]  char_code,

	// APB-style config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// ---------------------------------------------------------------- config
	logic layout_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= LAYOUT_US;
		end else if (cfg_wr && paddr[PADDR_W-1] == REG_LAYOUT_SELECT) begin
			layout_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_LAYOUT_SELECT) ?
			{{(PDATA_W-1){1'b0}}, layout_q} : '0;

	// ---------------------------------------------------------- stage 1 hold
	logic              valid_s1;
	logic [SCAN_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              s1_fire;
	logic              in_take;

	// s1 retires whenever the output register is empty or being drained
	assign s1_fire  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~s1_fire;
	assign in_take  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= scan_byte;
		end
	end

	// --------------------------------------------------------------- flag RAM
	// Single entry, read every cycle. The RAM is read-first, so a write at
	// the previous edge is not in rdata yet: forward it from fwd_flags_q.
	flags_t ram_rdata;
	flags_t flags_cur;
	flags_t flags_nxt;
	flags_t fwd_flags_q;
	logic   fwd_hit_q;
	logic   ram_init_q;

	sckd_ram #(
		.WIDTH (FLAG_W),
		.DEPTH (FLAG_DEPTH)
	) u_flag_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr ('0),
		.wdata (flags_nxt),
		.re    (1'b1),
		.raddr ('0),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q  <= 1'b0;
			ram_init_q <= 1'b0;
		end else begin
			fwd_hit_q <= s1_fire;
			if (s1_fire) begin
				ram_init_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fwd_flags_q <= flags_nxt;
		end
	end

	// entry never written reads as the reset value (all clear)
	always_comb begin
		if (fwd_hit_q) begin
			flags_cur = fwd_flags_q;
		end else if (ram_init_q) begin
			flags_cur = ram_rdata;
		end else begin
			flags_cur = '0;
		end
	end

	// ------------------------------------------------------------- decode
	event_kind_t       kind_nxt;
	logic [CHAR_W-1:0] char_nxt;
	glyph_pair_t       gp;
	logic [CHAR_W-1:0] gch;

	always_comb begin
		gp = (layout_q == LAYOUT_FR) ? fr_glyph(byte_s1[CHAR_W-1:0]) :
					       us_glyph(byte_s1[CHAR_W-1:0]);
		flags_nxt = flags_cur;
		kind_nxt  = EV_NONE;
		char_nxt  = '0;
		gch       = '0;

		if (byte_s1 == SC_PREFIX) begin
			// stays armed on repeated prefix bytes
			flags_nxt.prefix = 1'b1;
		end else if (flags_cur.prefix) begin
			flags_nxt.prefix = 1'b0;
			case (byte_s1)
				SC_LEFT:  kind_nxt = EV_LEFT;
				SC_RIGHT: kind_nxt = EV_RIGHT;
				SC_UP:    kind_nxt = EV_HPREV;
				SC_DOWN:  kind_nxt = EV_HNEXT;
				default:  kind_nxt = EV_NONE;
			endcase
		end else begin
			if (byte_s1 == SC_CAPS) begin
				flags_nxt.caps = ~flags_cur.caps;
			end
			if (byte_s1 == SC_LSHIFT || byte_s1 == SC_RSHIFT) begin
				flags_nxt.shift = 1'b1;
			end else if (byte_s1 == SC_LSHIFT_REL || byte_s1 == SC_RSHIFT_REL) begin
				flags_nxt.shift = 1'b0;
			end else if (byte_s1[SCAN_W-1]) begin
				kind_nxt = EV_NONE;  // other break codes
			end else if (byte_s1 == SC_ENTER && !flags_cur.shift) begin
				kind_nxt = EV_SUBMIT;
			end else if (byte_s1 == SC_BACKSPACE) begin
				kind_nxt = EV_BACKSPACE;
			end else begin
				// shift-enter falls through to the table newline
				gch = (flags_cur.shift ^ flags_nxt.caps) ? gp.hi : gp.lo;
				if (gch != '0) begin
					kind_nxt = EV_CHAR;
					char_nxt = gch;
				end
			end
		end
	end

	// ---------------------------------------------------------- output reg
	event_kind_t       kind_q;
	logic [CHAR_W-1:0] char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			kind_q <= kind_nxt;
			char_q <= char_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign char_code  = char_q;

endmodule

// ===== rtl/sckd_ram.sv =====
// ----------------------------------------------------------------------------
// sckd_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module sckd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sckd_checker.sv =====
// ----------------------------------------------------------------------------
// sckd_checker
// Port-level checks for the scancode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sckd_checker
	import sckd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [KIND_W-1:0] event_kind,
	input logic [CHAR_W-1:0] char_code
);

	// held word is not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// input backs up only behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a rising out_valid must follow an accepted input word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output word without matching input word");

	// char_code is set exactly for insert events
	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == EV_CHAR) == (char_code != '0)))
		else $error("char_code inconsistent with event_kind");

endmodule

bind scancode_to_key_event_decoder_unit sckd_checker u_sckd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_kind (event_kind),
	.char_code  (char_code)
);

// ===== dv/scancode_to_key_event_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// scancode_to_key_event_decoder_unit_tb
// Self-checking bench for the set-1 scancode decoder. Scancode words go in
// through a valid/stall sender with random gaps. Every accepted word runs
// through a local model of the decoder, which tracks the prefix, shift and
// caps flags and holds its own US and French keymaps. Each output word is
// compared with the oldest predicted key event. The layout register is
// written over the APB port between phases, while the block is idle.
// ----------------------------------------------------------------------------
module scancode_to_key_event_decoder_unit_tb;
	import sckd_pkg::*;

	localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
	localparam int QUIET_LIMIT  = 1000; // cycles with no handshake at all
	localparam int DRAIN_CYCLES = 4;    // settle time after the queue empties

	typedef struct {
		event_kind_t          kind;
		logic [CHAR_W-1:0]    ch;
	} key_event_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [SCAN_W-1:0]  scan_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [KIND_W-1:0]  event_kind;
	logic [CHAR_W-1:0]  char_code;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// decoder model state
	bit ext_armed;
	bit shift_down;
	bit caps_lock;
	bit layout_fr;

	key_event_t expected_events[$];
	int         mismatches = 0;
	int         bytes_sent = 0;
	int         quiet_cycles = 0;

	// idle knobs, percent per cycle
	int in_idle_pct = 30;
	int out_stall_pct = 30;

	// receiver hold-off request, served by its own process
	bit   hold_req = 1'b0;
	logic holding = 1'b0;

	scancode_to_key_event_decoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.scan_byte  (scan_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.char_code  (char_code),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Keymaps. Packed as two ASCII bytes: unshifted in [15:8], shifted in
	// [7:0]. A zero pair means the key has no glyph.
	// ------------------------------------------------------------------
	function automatic logic [15:0] us_keymap(input logic [6:0] code);
		case (code)
			7'h02: return "1!";
			7'h03: return "2@";
			7'h04: return "3#";
			7'h05: return "4$";
			7'h06: return "5%";
			7'h07: return "6^";
			7'h08: return "7&";
			7'h09: return "8*";
			7'h0A: return "9(";
			7'h0B: return "0)";
			7'h10: return "qQ";
			7'h11: return "wW";
			7'h12: return "eE";
			7'h13: return "rR";
			7'h14: return "tT";
			7'h15: return "yY";
			7'h16: return "uU";
			7'h17: return "iI";
			7'h18: return "oO";
			7'h19: return "pP";
			7'h1C: return "\n\n";
			7'h1E: return "aA";
			7'h1F: return "sS";
			7'h20: return "dD";
			7'h21: return "fF";
			7'h22: return "gG";
			7'h23: return "hH";
			7'h24: return "jJ";
			7'h25: return "kK";
			7'h26: return "lL";
			7'h2C: return "zZ";
			7'h2D: return "xX";
			7'h2E: return "cC";
			7'h2F: return "vV";
			7'h30: return "bB";
			7'h31: return "nN";
			7'h32: return "mM";
			7'h39: return "  ";
			default: return 16'h0000;
		endcase
	endfunction

	// French: AZERTY letters, digits on shift, accents folded to ASCII
	function automatic logic [15:0] fr_keymap(input logic [6:0] code);
		case (code)
			7'h02: return "&1";
			7'h03: return "e2";
			7'h04: return "\"3";
			7'h05: return "'4";
			7'h06: return "(5";
			7'h07: return "-6";
			7'h08: return "e7";
			7'h09: return "_8";
			7'h0A: return "c9";
			7'h0B: return "a0";
			7'h10: return "aA";
			7'h11: return "zZ";
			7'h1E: return "qQ";
			7'h2C: return "wW";
			7'h32: return ",?";
			default: return us_keymap(code);
		endcase
	endfunction

	// Decode one accepted scancode word into the expected key event.
	function automatic void predict_key_event(input logic [SCAN_W-1:0] code);
		key_event_t        ev;
		logic [15:0]       glyphs;
		logic [CHAR_W-1:0] ch;
		ev.kind = EV_NONE;
		ev.ch   = '0;
		if (code == SC_PREFIX) begin
			// a repeated prefix keeps the flag armed
			ext_armed = 1'b1;
		end else if (ext_armed) begin
			// prefixed word: only the arrows mean something, shift and caps stay
			ext_armed = 1'b0;
			case (code)
				SC_LEFT:  ev.kind = EV_LEFT;
				SC_RIGHT: ev.kind = EV_RIGHT;
				SC_UP:    ev.kind = EV_HPREV;
				SC_DOWN:  ev.kind = EV_HNEXT;
				default:  ev.kind = EV_NONE;
			endcase
		end else begin
			if (code == SC_CAPS)
				caps_lock = !caps_lock;
			if (code == SC_LSHIFT || code == SC_RSHIFT) begin
				shift_down = 1'b1;
			end else if (code == SC_LSHIFT_REL || code == SC_RSHIFT_REL) begin
				shift_down = 1'b0;
			end else if (code[7]) begin
				// any other break code is dropped
			end else if (code == SC_ENTER && !shift_down) begin
				ev.kind = EV_SUBMIT;
			end else if (code == SC_BACKSPACE) begin
				ev.kind = EV_BACKSPACE;
			end else begin
				// shifted enter lands here and yields a newline
				glyphs = layout_fr ? fr_keymap(code[6:0]) : us_keymap(code[6:0]);
				ch = (shift_down ^ caps_lock) ? glyphs[6:0] : glyphs[14:8];
				if (ch != '0) begin
					ev.kind = EV_CHAR;
					ev.ch   = ch;
				end
			end
		end
		expected_events.push_back(ev);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Monitor: predict on input handshake, then check on output handshake.
	// One process, so a same-edge push/pop never races. Also the watchdog.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_key_event(scan_byte);
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("unexpected word kind=%0d char=%02h",
						event_kind, char_code));
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind)
						report_mismatch($sformatf("event_kind got %0d want %0d (%s)",
							event_kind, want.kind, want.kind.name()));
					if (char_code !== want.ch)
						report_mismatch($sformatf("char_code got %02h want %02h",
							char_code, want.ch));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: random stall, forced high during a hold-off.
	always @(posedge clk) begin
		out_stall <= holding || ($urandom_range(0, 99) < out_stall_pct);
	end

	// Hold-off timer, counted here so the sender keeps pushing meanwhile.
	initial begin
		forever begin
			wait (hold_req);
			@(posedge clk);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
			hold_req = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Sender. Valid stays up into the next word unless a gap is drawn, so
	// valid is never dropped and raised in the same step.
	// ------------------------------------------------------------------
	task automatic send_scan(input logic [SCAN_W-1:0] code);
		in_valid  <= 1'b1;
		scan_byte <= code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid  <= 1'b0;
			scan_byte <= SCAN_W'($urandom);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted word has come out.
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write of layout_select, junk in the upper bits, then read back.
	task automatic write_layout(input bit fr);
		logic [PDATA_W-1:0] wdata;
		wdata    = PDATA_W'($urandom);
		wdata[0] = fr;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_LAYOUT_SELECT, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		layout_fr = fr;
		// back-to-back read, psel held
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== fr)
			report_mismatch($sformatf("layout_select read %0b want %0b", prdata[0], fr));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// A make code that has a glyph in both maps.
	function automatic logic [SCAN_W-1:0] random_glyph_key();
		case ($urandom_range(0, 4))
			0: return SCAN_W'($urandom_range('h02, 'h0B));
			1: return SCAN_W'($urandom_range('h10, 'h19));
			2: return SCAN_W'($urandom_range('h1E, 'h26));
			3: return SCAN_W'($urandom_range('h2C, 'h32));
			default: return SCAN_W'('h39);
		endcase
	endfunction

	// Mostly plausible typing: keys, shifted runs, caps, arrows, line keys,
	// with about a fifth raw noise bytes.
	task automatic type_random_keys(input int count);
		int                stop_at;
		int                pick;
		logic [SCAN_W-1:0] key;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				key = random_glyph_key();
				send_scan(key);
				if ($urandom_range(0, 3) == 0)
					send_scan(key | 8'h80);
			end else if (pick < 52) begin
				send_scan($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT);
				repeat ($urandom_range(1, 4)) send_scan(random_glyph_key());
				send_scan($urandom_range(0, 1) ? SC_LSHIFT_REL : SC_RSHIFT_REL);
			end else if (pick < 58) begin
				send_scan(SC_CAPS);
			end else if (pick < 72) begin
				send_scan(SC_PREFIX);
				if ($urandom_range(0, 5) == 0)
					send_scan(SC_PREFIX);
				case ($urandom_range(0, 5))
					0: send_scan(SC_LEFT);
					1: send_scan(SC_RIGHT);
					2: send_scan(SC_UP);
					3: send_scan(SC_DOWN);
					default: send_scan(SCAN_W'($urandom));
				endcase
			end else if (pick < 82) begin
				send_scan($urandom_range(0, 1) ? SC_ENTER : SC_BACKSPACE);
			end else begin
				send_scan(SCAN_W'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// US map out of reset: shift, caps, enter both ways, arrows, odd codes.
	task automatic test_directed_us;
		logic [SCAN_W-1:0] seq[$] = '{
			8'h1E, SC_LSHIFT, 8'h1E, 8'h02, SC_ENTER, SC_LSHIFT_REL, SC_ENTER,
			SC_BACKSPACE, SC_CAPS, 8'h1E, SC_RSHIFT, 8'h1E, SC_RSHIFT_REL,
			SC_CAPS, SC_PREFIX, SC_LEFT, SC_PREFIX, SC_PREFIX, SC_RIGHT,
			SC_PREFIX, SC_UP, SC_PREFIX, SC_DOWN, SC_PREFIX, 8'h1E,
			8'h9E, 8'h00, 8'h7F, 8'hFF
		};
		foreach (seq[i])
			send_scan(seq[i]);
		drain();
	endtask

	// French map: letters that move, symbol row, shifted comma.
	task automatic test_french_layout;
		logic [SCAN_W-1:0] seq[$] = '{
			8'h10, 8'h03, 8'h32, SC_LSHIFT, 8'h32, 8'h0B, SC_LSHIFT_REL
		};
		write_layout(LAYOUT_FR);
		foreach (seq[i])
			send_scan(seq[i]);
		drain();
	endtask

	task automatic test_random_typing(input bit fr, input int count);
		write_layout(fr);
		type_random_keys(count);
		drain();
	endtask

	// Receiver holds off while the sender streams; input must back up.
	task automatic test_output_holdoff;
		in_idle_pct   = 0;
		out_stall_pct = 0;
		hold_req      = 1'b1;
		type_random_keys(50);
		drain();
		in_idle_pct   = 30;
		out_stall_pct = 30;
	endtask

	// Full-rate stretch, no idling on either side.
	task automatic test_steady_stream(input bit fr);
		write_layout(fr);
		in_idle_pct   = 0;
		out_stall_pct = 0;
		type_random_keys(100);
		drain();
		in_idle_pct   = 30;
		out_stall_pct = 30;
	endtask

	initial begin
		ext_armed  = 1'b0;
		shift_down = 1'b0;
		caps_lock  = 1'b0;
		layout_fr  = LAYOUT_US;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_us();
		test_french_layout();
		test_random_typing(LAYOUT_US, 150);
		test_random_typing(LAYOUT_FR, 150);
		test_output_holdoff();
		test_steady_stream(LAYOUT_FR);
		test_random_typing(LAYOUT_US, 100);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
